### src/krirq_pkg.sv
// ----------------------------------------------------------------------------
// krirq_pkg
// Shared types, constants and the entry-to-key table of the keypad remap block.
// ----------------------------------------------------------------------------
package krirq_pkg;

	localparam int MapEntriesDefault = 13;
	localparam int BtnW    = 32;
	localparam int CtrlW   = 16;
	localparam int IdxW    = 4;
	localparam int KeyW    = 10;
	localparam int PressW  = 12;
	localparam int CtrlEnableBit = 14;
	localparam int CtrlAllBit    = 15;
	localparam int KeyABit = 0;
	localparam int KeyBBit = 1;
	localparam int RapidABit = 10;
	localparam int RapidBBit = 11;

	typedef enum logic {
		OP_SAMPLE    = 1'b0,
		OP_MAP_WRITE = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [BtnW-1:0]  host_buttons;
		logic [CtrlW-1:0] key_control;
		logic [IdxW-1:0]  map_index;
		logic [BtnW-1:0]  map_mask;
	} sample_t;

	typedef struct packed {
		logic [KeyW-1:0] key_register;
		logic            keypad_irq;
		logic            menu_request;
	} result_t;

	// console key driven by each mapping entry: ten keys, rapid A, rapid B, none
	function automatic logic [PressW-1:0] entry_key(input logic [IdxW-1:0] idx);
		logic [PressW-1:0] k;
		k = '0;
		case (idx)
			4'd0:    k = 12'h001;
			4'd1:    k = 12'h002;
			4'd2:    k = 12'h004;
			4'd3:    k = 12'h008;
			4'd4:    k = 12'h010;
			4'd5:    k = 12'h020;
			4'd6:    k = 12'h040;
			4'd7:    k = 12'h080;
			4'd8:    k = 12'h100;
			4'd9:    k = 12'h200;
			4'd10:   k = 12'h400;
			4'd11:   k = 12'h800;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

### src/krirq_if.sv
// ----------------------------------------------------------------------------
// krirq channel interfaces
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface krirq_in_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [krirq_pkg::BtnW-1:0]     host_buttons;
	logic [krirq_pkg::CtrlW-1:0]    key_control;
	logic [krirq_pkg::IdxW-1:0]     map_index;
	logic [krirq_pkg::BtnW-1:0]     map_mask;

	modport source (output valid, op, host_buttons, key_control, map_index, map_mask,
		input ready);
	modport sink (input valid, op, host_buttons, key_control, map_index, map_mask,
		output ready);
endinterface

interface krirq_out_if;
	logic                           valid;
	logic                           ready;
	logic [krirq_pkg::KeyW-1:0]     key_register;
	logic                           keypad_irq;
	logic                           menu_request;

	modport source (output valid, key_register, keypad_irq, menu_request, input ready);
	modport sink (input valid, key_register, keypad_irq, menu_request, output ready);
endinterface

### src/krirq_map_table.sv
// ----------------------------------------------------------------------------
// krirq_map_table
// Host button mask per console key; maps a button word onto the key set.
// ----------------------------------------------------------------------------
module krirq_map_table #(
	parameter int MAP_ENTRIES = krirq_pkg::MapEntriesDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [krirq_pkg::IdxW-1:0]    wr_index,
	input  logic [krirq_pkg::BtnW-1:0]    wr_mask,
	input  logic [krirq_pkg::BtnW-1:0]    host_buttons,
	output logic [krirq_pkg::PressW-1:0]  mapped_keys
);
	import krirq_pkg::*;

	logic [BtnW-1:0] table_q [MAP_ENTRIES];

	// an index past the last entry matches no row and is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_ENTRIES; i++) table_q[i] <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < MAP_ENTRIES; i++) begin
				if (wr_index == IdxW'(i)) table_q[i] <= wr_mask;
			end
		end
	end

	always_comb begin
		mapped_keys = '0;
		for (int i = 0; i < MAP_ENTRIES; i++) begin
			if (|(host_buttons & table_q[i])) mapped_keys = mapped_keys | entry_key(IdxW'(i));
		end
	end

endmodule

### src/krirq_key_logic.sv
// ----------------------------------------------------------------------------
// krirq_key_logic
// Edge detect, menu check, rapid fire, keypad interrupt and key state.
// ----------------------------------------------------------------------------
module krirq_key_logic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  krirq_pkg::sample_t            item,
	input  logic [krirq_pkg::BtnW-1:0]    home_mask,
	input  logic [krirq_pkg::PressW-1:0]  mapped_keys,
	output krirq_pkg::result_t            res
);
	import krirq_pkg::*;

	logic [BtnW-1:0]   previous_buttons_q;
	logic [PressW-1:0] pressed_keys_q;
	logic              rapid_phase_q;

	logic [BtnW-1:0]   fresh;
	logic              is_sample;
	logic              menu;
	logic [PressW-1:0] nk;
	logic              phase_b;
	logic              phase_next;
	logic [KeyW-1:0]   sel;
	logic [KeyW-1:0]   hit;
	logic              irq_mode_ok;
	logic              irq;

	assign is_sample = (item.op == OP_SAMPLE);
	assign fresh     = (previous_buttons_q ^ item.host_buttons) & item.host_buttons;
	assign menu      = is_sample && |(fresh & home_mask);

	// rapid A uses the phase first, rapid B sees it after A's flip
	assign phase_b    = mapped_keys[RapidABit] ? ~rapid_phase_q : rapid_phase_q;
	assign phase_next = rapid_phase_q ^ mapped_keys[RapidABit] ^ mapped_keys[RapidBBit];

	always_comb begin
		nk = mapped_keys;
		if (mapped_keys[RapidABit]) nk[KeyABit] = rapid_phase_q;
		if (mapped_keys[RapidBBit]) nk[KeyBBit] = phase_b;
	end

	assign sel = item.key_control[KeyW-1:0];
	assign hit = nk[KeyW-1:0] & sel;
	assign irq_mode_ok = item.key_control[CtrlAllBit] ? (hit == sel) : (|hit);
	assign irq = is_sample && !menu && ((nk | pressed_keys_q) != pressed_keys_q)
		&& item.key_control[CtrlEnableBit] && irq_mode_ok;

	always_comb begin
		res.keypad_irq   = irq;
		res.menu_request = menu;
		if (is_sample && !menu) begin
			res.key_register = ~nk[KeyW-1:0];
		end else begin
			res.key_register = ~pressed_keys_q[KeyW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_buttons_q <= '0;
			pressed_keys_q     <= '0;
			rapid_phase_q      <= 1'b1;
		end else if (commit && is_sample) begin
			previous_buttons_q <= item.host_buttons;
			if (!menu) begin
				pressed_keys_q <= nk;
				rapid_phase_q  <= phase_next;
			end
		end
	end

endmodule

### src/keypad_remap_irq_unit.sv
// ----------------------------------------------------------------------------
// keypad_remap_irq_unit
// Keypad remap with menu detection and keypad interrupt generation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  sample    in   valid/ready   op, host_buttons, key_control, map_index, map_mask
//  result    out  valid/ready   key_register, keypad_irq, menu_request
//  cfg       in   cfg_we        cfg_wdata -> home_mask
//
//  one item per cycle while the result is not stalled; an accepted sample
//  is held in the input register, then in the result register after the
//  mapping logic, where result.valid shows it
//  reset clears the key state, the mapping table and home_mask; rapid phase is one
//  a stalled result holds the result register and the item behind it, and
//  sample.ready drops only while both are full
// ----------------------------------------------------------------------------
module keypad_remap_irq_unit #(
	parameter int MAP_ENTRIES = krirq_pkg::MapEntriesDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	krirq_in_if.sink                    sample,
	krirq_out_if.source                 result,
	input  logic                        cfg_we,
	input  logic [krirq_pkg::BtnW-1:0]  cfg_wdata
);
	import krirq_pkg::*;

	logic              valid_s1;
	sample_t           item_s1;
	logic              out_valid_q;
	result_t           out_q;
	logic [BtnW-1:0]   home_mask_q;
	logic              advance;
	logic [PressW-1:0] mapped_keys;
	result_t           res;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_mask_q <= '0;
		end else if (cfg_we) begin
			home_mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1.op           <= op_t'(sample.op);
			item_s1.host_buttons <= sample.host_buttons;
			item_s1.key_control  <= sample.key_control;
			item_s1.map_index    <= sample.map_index;
			item_s1.map_mask     <= sample.map_mask;
		end
	end

	krirq_map_table #(
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_map_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (advance && item_s1.op == OP_MAP_WRITE),
		.wr_index     (item_s1.map_index),
		.wr_mask      (item_s1.map_mask),
		.host_buttons (item_s1.host_buttons),
		.mapped_keys  (mapped_keys)
	);

	krirq_key_logic u_key_logic (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (advance),
		.item        (item_s1),
		.home_mask   (home_mask_q),
		.mapped_keys (mapped_keys),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= res;
	end

	assign result.valid        = out_valid_q;
	assign result.key_register = out_q.key_register;
	assign result.keypad_irq   = out_q.keypad_irq;
	assign result.menu_request = out_q.menu_request;

`ifndef SYNTHESIS
	a_irq_menu_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.keypad_irq && result.menu_request))
		else $error("keypad irq and menu request raised together");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (valid_s1 && result.valid && !result.ready))
		else $error("sample stalled while a stage is free");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> valid_s1)
		else $error("accepted item lost from input stage");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid)
		else $error("advanced item missing at result");
`endif

endmodule
